// ----- src/prd_pkg.sv -----
package prd_pkg;

  // Default number of payload bytes in a write frame.
  localparam int unsigned PageBytesDefault = 1024;

  // Depth of the queue between the parser and the result stage.
  localparam int unsigned QueueDepth = 4;

  localparam logic [7:0]  LEAD_CMD   = 8'h34;
  localparam logic [7:0]  LEAD_READ  = 8'h52;
  localparam logic [3:0]  LEAD_WRITE = 4'h9;
  localparam logic [15:0] CMD_ENTER  = 16'h0510;
  localparam logic [15:0] CMD_LEAVE  = 16'h05EE;

  typedef enum logic [2:0] {
    KIND_PAYLOAD    = 3'd0,
    KIND_ENTER      = 3'd1,
    KIND_LEAVE      = 3'd2,
    KIND_READ       = 3'd3,
    KIND_WRITE_DONE = 3'd4,
    KIND_CSUM_ERR   = 3'd5,
    KIND_UNEXPECTED = 3'd6
  } kind_e;

  // One classified event on its way from the parser to the result stage.
  typedef struct packed {
    kind_e       kind;
    logic [15:0] page;
    logic [3:0]  segment;
    logic [7:0]  data;
    logic [9:0]  index;
    logic        frame_end;
  } event_t;

  // Queue status seen by the parser and the result stage.
  typedef struct packed {
    logic full;
    logic not_empty;
  } q_status_t;

endpackage

// ----- src/prd_front.sv -----
module prd_front #(
  parameter int unsigned PageBytes = prd_pkg::PageBytesDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       rx_byte_i,
  output logic             ev_valid_o,
  output prd_pkg::event_t  ev_o
);

  localparam int unsigned CntW = $clog2(PageBytes + 4);
  localparam int unsigned IdxW = (CntW > 10) ? CntW : 10;

  typedef enum logic [3:0] {
    FT_IDLE  = 4'b0001,
    FT_CMD   = 4'b0010,
    FT_READ  = 4'b0100,
    FT_WRITE = 4'b1000
  } frame_e;

  frame_e            frame_q, frame_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [7:0]        sum_q, sum_d;
  logic [15:0]       page_q, page_d;
  logic [3:0]        seg_q, seg_d;
  logic [15:0]       cmd_q, cmd_d;
  logic [CntW-1:0]   last_pos;
  logic [IdxW-1:0]   pay_pos;

  always_comb begin
    case (frame_q)
      FT_CMD:  last_pos = CntW'(4);
      FT_READ: last_pos = CntW'(3);
      default: last_pos = CntW'(PageBytes + 3);
    endcase
  end

  assign pay_pos = IdxW'(count_q) - IdxW'(3);

  always_comb begin
    frame_d    = frame_q;
    count_d    = count_q;
    sum_d      = sum_q;
    page_d     = page_q;
    seg_d      = seg_q;
    cmd_d      = cmd_q;
    ev_valid_o = 1'b0;
    ev_o       = '0;
    if (accept_i) begin
      if (frame_q == FT_IDLE) begin
        page_d  = '0;
        seg_d   = '0;
        cmd_d   = '0;
        count_d = CntW'(1);
        sum_d   = rx_byte_i;
        if (rx_byte_i == prd_pkg::LEAD_CMD) begin
          frame_d = FT_CMD;
        end else if (rx_byte_i == prd_pkg::LEAD_READ) begin
          frame_d = FT_READ;
        end else if (rx_byte_i[7:4] == prd_pkg::LEAD_WRITE) begin
          frame_d = FT_WRITE;
          seg_d   = rx_byte_i[3:0];
        end else begin
          // A stray lead byte is reported and the parser stays idle.
          count_d         = count_q;
          sum_d           = sum_q;
          ev_valid_o      = 1'b1;
          ev_o.kind       = prd_pkg::KIND_UNEXPECTED;
          ev_o.frame_end  = 1'b1;
        end
      end else if (count_q >= last_pos) begin
        frame_d        = FT_IDLE;
        count_d        = '0;
        sum_d          = '0;
        ev_valid_o     = 1'b1;
        ev_o.frame_end = 1'b1;
        if (sum_q != rx_byte_i) begin
          ev_o.kind    = prd_pkg::KIND_CSUM_ERR;
          ev_o.page    = page_q;
          ev_o.segment = seg_q;
        end else if (frame_q == FT_CMD) begin
          if (cmd_q == prd_pkg::CMD_ENTER) begin
            ev_o.kind = prd_pkg::KIND_ENTER;
          end else if (cmd_q == prd_pkg::CMD_LEAVE) begin
            ev_o.kind = prd_pkg::KIND_LEAVE;
          end else begin
            ev_o.kind = prd_pkg::KIND_UNEXPECTED;
          end
        end else if (frame_q == FT_READ) begin
          ev_o.kind = prd_pkg::KIND_READ;
          ev_o.page = page_q;
        end else begin
          ev_o.kind    = prd_pkg::KIND_WRITE_DONE;
          ev_o.page    = page_q;
          ev_o.segment = seg_q;
        end
      end else begin
        sum_d   = sum_q + rx_byte_i;
        count_d = count_q + CntW'(1);
        if (frame_q == FT_CMD) begin
          if (count_q == CntW'(2)) begin
            cmd_d = {rx_byte_i, cmd_q[7:0]};
          end else if (count_q == CntW'(3)) begin
            cmd_d = {cmd_q[15:8], rx_byte_i};
          end
        end else if (count_q == CntW'(1)) begin
          page_d = {rx_byte_i, page_q[7:0]};
        end else if (count_q == CntW'(2)) begin
          page_d = {page_q[15:8], rx_byte_i};
        end else if (frame_q == FT_WRITE) begin
          ev_valid_o   = 1'b1;
          ev_o.kind    = prd_pkg::KIND_PAYLOAD;
          ev_o.page    = page_q;
          ev_o.segment = seg_q;
          ev_o.data    = rx_byte_i;
          ev_o.index   = pay_pos[9:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= FT_IDLE;
      count_q <= '0;
      sum_q   <= '0;
      page_q  <= '0;
      seg_q   <= '0;
      cmd_q   <= '0;
    end else begin
      frame_q <= frame_d;
      count_q <= count_d;
      sum_q   <= sum_d;
      page_q  <= page_d;
      seg_q   <= seg_d;
      cmd_q   <= cmd_d;
    end
  end

endmodule

// ----- src/prd_queue.sv -----
module prd_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  prd_pkg::event_t      push_data_i,
  input  logic                 pop_i,
  output prd_pkg::event_t      head_o,
  output prd_pkg::q_status_t   status_o
);

  localparam int unsigned PtrW = $clog2(prd_pkg::QueueDepth);
  localparam int unsigned CntW = $clog2(prd_pkg::QueueDepth + 1);

  prd_pkg::event_t  slots_q [prd_pkg::QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;

  assign head_o             = slots_q[rd_ptr_q];
  assign status_o.full      = (count_q == CntW'(prd_pkg::QueueDepth));
  assign status_o.not_empty = (count_q != '0);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + CntW'(1);
        2'b01:   count_q <= count_q - CntW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ----- src/prd_back.sv -----
module prd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  prd_pkg::event_t     head_i,
  input  prd_pkg::q_status_t  status_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [2:0]          result_kind_o,
  output logic [15:0]         page_o,
  output logic [3:0]          segment_o,
  output logic [28:0]         address_o,
  output logic [7:0]          data_byte_o,
  output logic [9:0]          byte_index_o,
  output logic                frame_end_o
);

  logic            valid_q;
  prd_pkg::event_t ev_q;
  logic [28:0]     addr_q, addr_d;

  // The output register reloads whenever it is empty or being taken and the queue holds an item.
  assign pop_o = status_i.not_empty && (!valid_q || !out_stall_i);

  always_comb begin
    case (head_i.kind)
      prd_pkg::KIND_READ: begin
        addr_d = {3'b000, head_i.page, 10'b0};
      end
      prd_pkg::KIND_PAYLOAD, prd_pkg::KIND_WRITE_DONE: begin
        addr_d = {1'b0, head_i.segment, 24'b0} + {3'b000, head_i.page, 10'b0};
      end
      default: begin
        addr_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ev_q   <= head_i;
      addr_q <= addr_d;
    end
  end

  assign out_valid_o   = valid_q;
  assign result_kind_o = ev_q.kind;
  assign page_o        = ev_q.page;
  assign segment_o     = ev_q.segment;
  assign address_o     = addr_q;
  assign data_byte_o   = ev_q.data;
  assign byte_index_o  = ev_q.index;
  assign frame_end_o   = ev_q.frame_end;

endmodule

// ----- src/programming_request_deframer.sv -----
// Channel   Direction  Handshake                 Payload
// request   in         in_valid_i / in_stall_o   rx_byte_i
// result    out        out_valid_o / out_stall_i result_kind_o, page_o, segment_o,
//                                                address_o, data_byte_o, byte_index_o,
//                                                frame_end_o
//
// One byte is taken per cycle while in_stall_o is low; the parser updates its
// counter and running sum; each item goes via the queue to the output register.
// A four-item queue sits between the parser and the output register, so input
// is stalled only once that queue has filled behind a stalled output.
// Reset is asynchronous and leaves the parser idle, awaiting a lead byte.
module programming_request_deframer #(
  parameter int unsigned PageBytes = prd_pkg::PageBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  result_kind_o,
  output logic [15:0] page_o,
  output logic [3:0]  segment_o,
  output logic [28:0] address_o,
  output logic [7:0]  data_byte_o,
  output logic [9:0]  byte_index_o,
  output logic        frame_end_o
);

  logic               accept;
  logic               ev_valid;
  prd_pkg::event_t    ev;
  prd_pkg::event_t    head;
  prd_pkg::q_status_t q_status;
  logic               pop;

  assign in_stall_o = q_status.full;
  assign accept     = in_valid_i && !q_status.full;

  prd_front #(
    .PageBytes (PageBytes)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .rx_byte_i  (rx_byte_i),
    .ev_valid_o (ev_valid),
    .ev_o       (ev)
  );

  prd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (ev_valid),
    .push_data_i (ev),
    .pop_i       (pop),
    .head_o      (head),
    .status_o    (q_status)
  );

  prd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .status_i      (q_status),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .result_kind_o (result_kind_o),
    .page_o        (page_o),
    .segment_o     (segment_o),
    .address_o     (address_o),
    .data_byte_o   (data_byte_o),
    .byte_index_o  (byte_index_o),
    .frame_end_o   (frame_end_o)
  );

endmodule

// ----- src/prd_checker.sv -----
module prd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_stall_i,
  input logic [2:0]  result_kind_i,
  input logic [15:0] page_i,
  input logic [28:0] address_i,
  input logic [7:0]  data_byte_i,
  input logic [9:0]  byte_index_i,
  input logic        frame_end_i
);

  // A stalled result holds its kind and its end marker.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(result_kind_i)
      && $stable(frame_end_i))
    else $error("stalled result changed");

  // Only payload items leave a frame open.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (frame_end_i == (result_kind_i != prd_pkg::KIND_PAYLOAD)))
    else $error("frame end marker does not match result kind");

  // Data byte and index are zero on every result but a payload byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (result_kind_i != prd_pkg::KIND_PAYLOAD)
      |-> (data_byte_i == 8'd0) && (byte_index_i == 10'd0))
    else $error("payload fields set on a non-payload result");

  // A read reports as its address the page shifted up by ten bits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (result_kind_i == prd_pkg::KIND_READ)
      |-> (address_i == {3'b000, page_i, 10'b0}))
    else $error("read address does not match page");

  // Kind codes above the unexpected code never appear.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (result_kind_i <= prd_pkg::KIND_UNEXPECTED))
    else $error("undefined result kind");

endmodule

bind programming_request_deframer prd_checker u_prd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .result_kind_i (result_kind_o),
  .page_i        (page_o),
  .address_i     (address_o),
  .data_byte_i   (data_byte_o),
  .byte_index_i  (byte_index_o),
  .frame_end_i   (frame_end_o)
);
